### rtl/ffha_pkg.sv
// ============================================================================
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Holds field widths, heap layout sizes, request kinds, result codes and the
// controller states.
package ffha_pkg;

  // Field widths fixed by the interface.
  localparam int FW = 21;                 // byte counts and offsets
  localparam int SW = 22;                 // rounded request, may reach 2^21

  // Heap layout.
  localparam logic [FW-1:0] HDR_BYTES    = 21'd24;
  localparam logic [FW-1:0] FIRST_HDR    = 21'd8;
  localparam logic [FW-1:0] MIN_SPLIT    = 21'd16;
  localparam logic [FW-1:0] DEFAULT_HEAP = 21'h10000;
  localparam logic [FW-1:0] HEAP_LIMIT   = 21'd1048576;

  // Request kinds.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_POP,
    S_A_WB,
    S_F_RD,
    S_F_CHK,
    S_M_RD0,
    S_M_LD,
    S_M_ITER,
    S_M_CMP,
    S_M_WN,
    S_RESP
  } state_t;

endpackage

### rtl/first_fit_heap_allocator.sv
// ============================================================================
// first_fit_heap_allocator: address-ordered first-fit heap manager
// Block entries live in a synchronous entry memory and spare entry numbers in
// a spare stack memory; a sequencer walks the chain one entry at a time.
// ============================================================================
// One request is handled at a time. An allocate walks the address-ordered
// chain of block entries, reading and then checking each entry visited; a
// split pops a spare entry for the remainder and then writes back the taken
// block, and the result is held until it is handed over. A free walks the
// chain the same way to find the block and then runs a merge pass over the
// chain from its head, joining each free entry with a free successor and
// retiring the absorbed entry. Writing cfg_heap_size while idle sets the
// region up again; no clearing pass is needed.
module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 21
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [ffha_pkg::FW-1:0] cfg_heap_size,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [ffha_pkg::FW-1:0] in_byte_count,
  input  logic [ffha_pkg::FW-1:0] in_block_address,
  input  logic                 in_zero_fill,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ffha_pkg::FW-1:0] out_payload_address,
  output logic [ffha_pkg::FW-1:0] out_clear_length,
  output logic [1:0]           out_status
);
  import ffha_pkg::*;

  localparam int LW = $clog2(MAX_BLOCKS);     // entry number
  localparam int KW = LW + 1;                 // link, with end marker
  localparam int GW = LW + 2;                 // merge guard count
  localparam logic [KW-1:0] LINK_END = KW'(MAX_BLOCKS);
  localparam logic [KW-1:0] LAST_SPARE = KW'(MAX_BLOCKS - 1);
  localparam logic [GW-1:0] GUARD_MAX = GW'(2 * MAX_BLOCKS);
  localparam logic [FW-1:0] AMASK =
    (ADDR_BITS >= FW) ? {FW{1'b1}} : FW'((64'd1 << ADDR_BITS) - 64'd1);

  typedef struct packed {
    logic [FW-1:0] offset;
    logic [FW-1:0] size;
    logic          is_free;
    logic [KW-1:0] link;
  } entry_t;

  // Memories.
  entry_t        entry_mem [MAX_BLOCKS];
  logic [LW-1:0] spare_mem [MAX_BLOCKS];

  state_t        state_r, state_nxt;
  logic [FW-1:0] region_r, region_nxt;
  logic          e0_init_r, e0_init_nxt;
  logic [KW-1:0] spare_cnt_r, spare_cnt_nxt;
  logic [KW-1:0] spare_min_r, spare_min_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] nxt_r, nxt_nxt;
  logic [KW-1:0] steps_r, steps_nxt;
  logic [GW-1:0] guard_r, guard_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic          zf_r, zf_nxt;
  logic [FW-1:0] addr_r, addr_nxt;
  entry_t        ent_r, ent_nxt;
  logic [FW-1:0] res_pay_r, res_pay_nxt;
  logic [FW-1:0] res_clr_r, res_clr_nxt;
  status_t       res_st_r, res_st_nxt;
  logic          rd0_r;

  // Memory port controls.
  logic [LW-1:0] rd_addr;
  entry_t        rd_q, ent_q;
  logic          wr_en;
  logic [LW-1:0] wr_addr;
  entry_t        wr_data;
  logic          sp_wr_en;
  logic [LW-1:0] sp_rd_addr, sp_q;
  logic [KW-1:0] sp_rd_idx_r;
  logic [SW:0]   split_need;
  logic [SW-1:0] req_round;
  logic [FW-1:0] cfg_region;
  logic [LW-1:0] pop_entry;
  entry_t        merged;

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    rd_q  <= entry_mem[rd_addr];
    rd0_r <= (rd_addr == '0);
  end

  // Spare stack memory.
  always_ff @(posedge clk) begin
    if (sp_wr_en) begin
      spare_mem[spare_cnt_r[LW-1:0]] <= nxt_r;
    end
    sp_q        <= spare_mem[sp_rd_addr];
    sp_rd_idx_r <= {1'b0, sp_rd_addr};
  end

  // Entry 0 reads as the fresh region until it is first written.
  always_comb begin
    ent_q = rd_q;
    if (rd0_r && e0_init_r) begin
      ent_q = '{offset: FIRST_HDR, size: region_r, is_free: 1'b1, link: LINK_END};
    end
  end

  // Spare slots below the lowest pushed slot still hold the setup order.
  assign pop_entry = (sp_rd_idx_r >= spare_min_r) ? sp_q
                   : LW'(LAST_SPARE - sp_rd_idx_r);

  // Helper arithmetic.
  always_comb begin
    req_round = ({1'b0, (in_byte_count == '0) ? FW'(1) : in_byte_count} + SW'(7))
              & ~SW'(7);
    split_need = {1'b0, size_r} + (SW + 1)'(HDR_BYTES + MIN_SPLIT);
    if (cfg_heap_size > HEAP_LIMIT) begin
      cfg_region = HEAP_LIMIT;
    end else if (cfg_heap_size == '0) begin
      cfg_region = DEFAULT_HEAP;
    end else begin
      cfg_region = (cfg_heap_size + FW'(7)) & ~FW'(7);
    end
    merged        = ent_r;
    merged.size   = ent_r.size + HDR_BYTES + ent_q.size;
    merged.link   = ent_q.link;
  end

  // Next state and datapath.
  always_comb begin
    state_nxt     = state_r;
    region_nxt    = region_r;
    e0_init_nxt   = e0_init_r;
    spare_cnt_nxt = spare_cnt_r;
    spare_min_nxt = spare_min_r;
    cur_nxt       = cur_r;
    nxt_nxt       = nxt_r;
    steps_nxt     = steps_r;
    guard_nxt     = guard_r;
    size_nxt      = size_r;
    zf_nxt        = zf_r;
    addr_nxt      = addr_r;
    ent_nxt       = ent_r;
    res_pay_nxt   = res_pay_r;
    res_clr_nxt   = res_clr_r;
    res_st_nxt    = res_st_r;
    rd_addr       = cur_r;
    wr_en         = 1'b0;
    wr_addr       = cur_r;
    wr_data       = ent_r;
    sp_wr_en      = 1'b0;
    sp_rd_addr    = LW'(spare_cnt_r - KW'(1));
    case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          region_nxt    = cfg_region;
          e0_init_nxt   = 1'b1;
          spare_cnt_nxt = LAST_SPARE;
          spare_min_nxt = LINK_END;
        end else if (in_valid) begin
          cur_nxt     = '0;
          steps_nxt   = '0;
          size_nxt    = req_round;
          zf_nxt      = in_zero_fill;
          addr_nxt    = in_block_address & AMASK;
          res_pay_nxt = '0;
          res_clr_nxt = '0;
          res_st_nxt  = ST_OK;
          if (in_mode == MODE_ALLOC) begin
            state_nxt = S_A_RD;
          end else if (in_block_address == '0) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_F_RD;
          end
        end
      end
      S_A_RD, S_F_RD: begin
        state_nxt = (state_r == S_A_RD) ? S_A_CHK : S_F_CHK;
      end
      S_A_CHK: begin
        ent_nxt = ent_q;
        if (ent_q.is_free && ({1'b0, ent_q.size} >= size_r)) begin
          if (({2'b0, ent_q.size} >= split_need) && (spare_cnt_r != '0)) begin
            state_nxt = S_A_POP;
          end else begin
            wr_en           = 1'b1;
            wr_data         = ent_q;
            wr_data.is_free = 1'b0;
            e0_init_nxt     = e0_init_r && (cur_r != '0);
            res_pay_nxt     = ent_q.offset + HDR_BYTES;
            res_clr_nxt     = zf_r ? ent_q.size : '0;
            state_nxt       = S_RESP;
          end
        end else begin
          steps_nxt = steps_r + KW'(1);
          if ((ent_q.link >= LINK_END) || (steps_r + KW'(1) >= LINK_END)) begin
            res_st_nxt = ST_NO_FIT;
            state_nxt  = S_RESP;
          end else begin
            cur_nxt   = ent_q.link[LW-1:0];
            state_nxt = S_A_RD;
          end
        end
      end
      S_A_POP: begin
        // New free entry for the remainder.
        spare_cnt_nxt   = spare_cnt_r - KW'(1);
        nxt_nxt         = pop_entry;
        wr_en           = 1'b1;
        wr_addr         = pop_entry;
        wr_data.offset  = ent_r.offset + HDR_BYTES + size_r[FW-1:0];
        wr_data.size    = ent_r.size - size_r[FW-1:0] - HDR_BYTES;
        wr_data.is_free = 1'b1;
        wr_data.link    = ent_r.link;
        state_nxt       = S_A_WB;
      end
      S_A_WB: begin
        wr_en           = 1'b1;
        wr_data.size    = size_r[FW-1:0];
        wr_data.is_free = 1'b0;
        wr_data.link    = {1'b0, nxt_r};
        e0_init_nxt     = e0_init_r && (cur_r != '0);
        res_pay_nxt     = ent_r.offset + HDR_BYTES;
        res_clr_nxt     = zf_r ? size_r[FW-1:0] : '0;
        state_nxt       = S_RESP;
      end
      S_F_CHK: begin
        if (((ent_q.offset + HDR_BYTES) & AMASK) == addr_r) begin
          wr_en           = 1'b1;
          wr_data         = ent_q;
          wr_data.is_free = 1'b1;
          e0_init_nxt     = e0_init_r && (cur_r != '0);
          state_nxt       = S_M_RD0;
        end else begin
          steps_nxt = steps_r + KW'(1);
          if ((ent_q.link >= LINK_END) || (steps_r + KW'(1) >= LINK_END)) begin
            res_st_nxt = ST_BAD_ADDR;
            state_nxt  = S_RESP;
          end else begin
            cur_nxt   = ent_q.link[LW-1:0];
            state_nxt = S_F_RD;
          end
        end
      end
      S_M_RD0: begin
        cur_nxt   = '0;
        guard_nxt = '0;
        rd_addr   = '0;
        state_nxt = S_M_LD;
      end
      S_M_LD: begin
        ent_nxt   = ent_q;
        state_nxt = S_M_ITER;
      end
      S_M_ITER: begin
        // Look at the successor of the current entry.
        if ((guard_r >= GUARD_MAX) || (ent_r.link >= LINK_END)) begin
          state_nxt = S_RESP;
        end else begin
          guard_nxt = guard_r + GW'(1);
          nxt_nxt   = ent_r.link[LW-1:0];
          rd_addr   = ent_r.link[LW-1:0];
          state_nxt = S_M_CMP;
        end
      end
      S_M_CMP: begin
        if (ent_r.is_free && ent_q.is_free) begin
          wr_en       = 1'b1;
          wr_data     = merged;
          ent_nxt     = merged;
          e0_init_nxt = e0_init_r && (cur_r != '0);
          state_nxt   = S_M_WN;
        end else begin
          cur_nxt   = nxt_r;
          ent_nxt   = ent_q;
          state_nxt = S_M_ITER;
        end
      end
      S_M_WN: begin
        // Retire the absorbed entry and return it to the spare stack.
        wr_en           = 1'b1;
        wr_addr         = nxt_r;
        wr_data         = '0;
        wr_data.is_free = 1'b0;
        wr_data.link    = LINK_END;
        e0_init_nxt     = e0_init_r && (nxt_r != '0);
        if (spare_cnt_r < LINK_END) begin
          sp_wr_en      = 1'b1;
          spare_cnt_nxt = spare_cnt_r + KW'(1);
          if (spare_cnt_r < spare_min_r) begin
            spare_min_nxt = spare_cnt_r;
          end
        end
        state_nxt = S_M_ITER;
      end
      S_RESP: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready            = (state_r == S_IDLE) && !cfg_we;
    out_valid           = (state_r == S_RESP);
    out_payload_address = res_pay_r;
    out_clear_length    = res_clr_r;
    out_status          = res_st_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      region_r    <= DEFAULT_HEAP;
      e0_init_r   <= 1'b1;
      spare_cnt_r <= LAST_SPARE;
      spare_min_r <= LINK_END;
    end else begin
      state_r     <= state_nxt;
      region_r    <= region_nxt;
      e0_init_r   <= e0_init_nxt;
      spare_cnt_r <= spare_cnt_nxt;
      spare_min_r <= spare_min_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    nxt_r     <= nxt_nxt;
    steps_r   <= steps_nxt;
    guard_r   <= guard_nxt;
    size_r    <= size_nxt;
    zf_r      <= zf_nxt;
    addr_r    <= addr_nxt;
    ent_r     <= ent_nxt;
    res_pay_r <= res_pay_nxt;
    res_clr_r <= res_clr_nxt;
    res_st_r  <= res_st_nxt;
  end

`ifndef SYNTHESIS
  // The spare stack never holds more than every entry but the head.
  assert property (@(posedge clk) disable iff (!rst_n) spare_cnt_r <= LAST_SPARE)
    else $error("spare stack overflow");
  // A new request is never taken while a result is pending.
  assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input taken while result pending");
  // A split pops only from a non-empty spare stack.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_POP) |-> ($past(spare_cnt_r) != '0))
    else $error("pop from empty spare stack");
  // A result transfer returns the sequencer to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle");
`endif

endmodule
